/* rtl/core/pradf_pkg.sv */
// Shared types and constants for the PN replay A-MSDU flip detector.
package pradf_pkg;

  // Field widths of one observed frame
  localparam int unsigned ADDR_W = 48;
  localparam int unsigned PN_W   = 48;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned WIN_W  = 16;

  // Default table depth
  localparam int unsigned TABLE_ENTRIES_DEF = 64;

  // Window value after reset, in seconds
  localparam logic [WIN_W-1:0] WINDOW_RST = 16'd10;

  // Byte-padded stream widths
  localparam int unsigned S_TDATA_W = 128;
  localparam int unsigned M_TDATA_W = 8;

  // One stored table entry
  typedef struct packed {
    logic [TIME_W-1:0] stamp;
    logic              agg;
    logic [PN_W-1:0]   pn;
    logic [ADDR_W-1:0] ta;
  } entry_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_e;

endpackage

/* rtl/core/pn_replay_amsdu_flip_detector_unit.sv */
// Top level: PN replay detector that flags A-MSDU bit flips over a table of recent frames.
//
//  channel  | dir | handshake                        | payload
//  ---------+-----+----------------------------------+-------------------------------------
//  s_axis   | in  | s_axis_tvalid / s_axis_tready    | tdata: ta, pn, timestamp; tuser: agg
//  m_axis   | out | m_axis_tvalid / m_axis_tready    | tdata: flip_detected (bit 0)
//  cfg      | in  | cfg_valid_i / cfg_ready_o        | window_seconds (16 bits)
//
// Each item scans up to entry_count entries (at most TableEntries): one entry of the
// table memory is read per cycle over the single read port, then the write state follows.
// A replay hit ends the scan early. The input is not ready while an item is in work.
// Reset empties the table (entry count to zero) at once and sets the window to 10 s.
// A result waiting in the output register does not block the next item; the write
// cycle holds only when the output register is still full.
module pn_replay_amsdu_flip_detector_unit #(
  parameter int unsigned TableEntries = pradf_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input frames
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [47:0] transmitter, [95:48] packet_number, [127:96] timestamp
  input  logic [pradf_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // [0] aggregated
  input  logic                             s_axis_tuser,
  // results
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] flip_detected, [7:1] zero
  output logic [pradf_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // window register
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [pradf_pkg::WIN_W-1:0]      cfg_data_i
);

  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned CntW = $clog2(TableEntries + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(TableEntries);

  // Table memory
  pradf_pkg::entry_t mem_q [TableEntries];
  pradf_pkg::entry_t rd_data_q;

  // Control and context
  pradf_pkg::state_e state_q, state_d;
  logic [pradf_pkg::WIN_W-1:0]  window_q;
  logic [CntW-1:0]              count_q, count_d;
  logic [CntW-1:0]              rd_idx_q, rd_idx_d;
  logic                         pend_q, pend_d;
  logic [IdxW-1:0]              pend_idx_q, pend_idx_d;
  logic                         hit_q, hit_d;
  logic [IdxW-1:0]              hit_idx_q, hit_idx_d;
  logic                         flip_q, flip_d;
  logic                         have_slot_q, have_slot_d;
  logic [IdxW-1:0]              aged_idx_q, aged_idx_d;
  logic [IdxW-1:0]              min_idx_q, min_idx_d;
  logic [pradf_pkg::TIME_W-1:0] min_time_q, min_time_d;
  logic                         out_valid_q, out_valid_d;
  logic                         out_flip_q;

  // Captured frame
  logic [pradf_pkg::ADDR_W-1:0] in_ta_q;
  logic [pradf_pkg::PN_W-1:0]   in_pn_q;
  logic                         in_agg_q;
  logic [pradf_pkg::TIME_W-1:0] in_time_q;

  // Datapath signals
  logic                         accept;
  logic                         rd_en;
  logic [IdxW-1:0]              rd_addr;
  logic                         wr_en;
  logic [IdxW-1:0]              wr_addr;
  pradf_pkg::entry_t            wr_data;
  logic [pradf_pkg::TIME_W:0]   age;
  logic                         aged;
  logic                         match;
  logic                         out_free;

  assign s_axis_tready = (state_q == pradf_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(pradf_pkg::M_TDATA_W-1){1'b0}}, out_flip_q};

  // Shared compare unit: age test and key match on the entry just read
  assign age   = {1'b0, in_time_q} - {1'b0, rd_data_q.stamp};
  assign aged  = !age[pradf_pkg::TIME_W] &&
                 (age[pradf_pkg::TIME_W-1:0] >
                  {{(pradf_pkg::TIME_W-pradf_pkg::WIN_W){1'b0}}, window_q});
  assign match = (rd_data_q.ta == in_ta_q) && (rd_data_q.pn == in_pn_q);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    pend_d      = 1'b0;
    pend_idx_d  = pend_idx_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    flip_d      = flip_q;
    have_slot_d = have_slot_q;
    aged_idx_d  = aged_idx_q;
    min_idx_d   = min_idx_q;
    min_time_d  = min_time_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    rd_en       = 1'b0;
    rd_addr     = rd_idx_q[IdxW-1:0];
    wr_en       = 1'b0;
    wr_addr     = aged_idx_q;
    wr_data     = '{stamp: in_time_q, agg: in_agg_q, pn: in_pn_q, ta: in_ta_q};

    case (state_q)
      pradf_pkg::ST_IDLE: begin
        if (accept) begin
          rd_idx_d    = '0;
          hit_d       = 1'b0;
          flip_d      = 1'b0;
          have_slot_d = 1'b0;
          state_d     = pradf_pkg::ST_SCAN;
        end
      end

      pradf_pkg::ST_SCAN: begin
        // check the entry returned by last cycle's read
        if (pend_q) begin
          if (pend_idx_q == '0 || rd_data_q.stamp < min_time_q) begin
            min_idx_d  = pend_idx_q;
            min_time_d = rd_data_q.stamp;
          end
          if (aged) begin
            if (!have_slot_q) begin
              have_slot_d = 1'b1;
              aged_idx_d  = pend_idx_q;
            end
          end else if (match) begin
            hit_d     = 1'b1;
            hit_idx_d = pend_idx_q;
            flip_d    = rd_data_q.agg != in_agg_q;
          end
        end
        if (pend_q && !aged && match) begin
          state_d = pradf_pkg::ST_WRITE;
        end else if (rd_idx_q < count_q) begin
          rd_en      = 1'b1;
          pend_d     = 1'b1;
          pend_idx_d = rd_idx_q[IdxW-1:0];
          rd_idx_d   = rd_idx_q + 1'b1;
        end else begin
          state_d = pradf_pkg::ST_WRITE;
        end
      end

      pradf_pkg::ST_WRITE: begin
        // pick the target slot and publish the result together
        if (out_free) begin
          wr_en       = 1'b1;
          out_valid_d = 1'b1;
          state_d     = pradf_pkg::ST_IDLE;
          if (hit_q) begin
            wr_addr     = hit_idx_q;
            wr_data.agg = in_agg_q ^ flip_q;
          end else if (have_slot_q) begin
            wr_addr = aged_idx_q;
          end else if (count_q < CntMax) begin
            wr_addr = count_q[IdxW-1:0];
            count_d = count_q + 1'b1;
          end else begin
            wr_addr = min_idx_q;
          end
        end
      end

      default: begin
        state_d = pradf_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pradf_pkg::ST_IDLE;
      window_q    <= pradf_pkg::WINDOW_RST;
      count_q     <= '0;
      rd_idx_q    <= '0;
      pend_q      <= 1'b0;
      hit_q       <= 1'b0;
      have_slot_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      pend_q      <= pend_d;
      hit_q       <= hit_d;
      have_slot_q <= have_slot_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        window_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    hit_idx_q  <= hit_idx_d;
    flip_q     <= flip_d;
    aged_idx_q <= aged_idx_d;
    min_idx_q  <= min_idx_d;
    min_time_q <= min_time_d;
    if (accept) begin
      in_ta_q   <= s_axis_tdata[47:0];
      in_pn_q   <= s_axis_tdata[95:48];
      in_time_q <= s_axis_tdata[127:96];
      in_agg_q  <= s_axis_tuser;
    end
    if (wr_en) begin
      out_flip_q <= flip_q;
    end
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // Checks
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntMax)
    else $error("entry count beyond table depth");

  a_scan_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_idx_q <= count_q || state_q == pradf_pkg::ST_IDLE)
    else $error("scan index past entry count");

  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != $past(count_q) |-> count_q == $past(count_q) + 1'b1)
    else $error("entry count moved by more than one");

  a_write_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> out_valid_q && state_q == pradf_pkg::ST_IDLE)
    else $error("table write without a result");

  a_accept_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == pradf_pkg::ST_SCAN && rd_idx_q == '0)
    else $error("accepted frame did not start a scan");

endmodule

/* tb/pn_replay_amsdu_flip_detector_unit_tb.sv */
`timescale 1ns / 100ps
// Testbench for the PN replay A-MSDU flip detector: replay table model, frame traffic, stalls.
module pn_replay_amsdu_flip_detector_unit_tb;

  localparam int unsigned SLOTS       = pradf_pkg::TABLE_ENTRIES_DEF;
  // worst case per frame: full scan plus the write cycle
  localparam int unsigned ITEM_CYCLES = SLOTS + 3;
  localparam logic [pradf_pkg::ADDR_W-1:0] TA_ONES = '1;
  localparam logic [pradf_pkg::PN_W-1:0]   PN_ONES = '1;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  // [47:0] transmitter, [95:48] packet_number, [127:96] timestamp
  logic [pradf_pkg::S_TDATA_W-1:0] s_axis_tdata;
  // [0] aggregated
  logic                            s_axis_tuser;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  // [0] flip_detected, [7:1] zero
  logic [pradf_pkg::M_TDATA_W-1:0] m_axis_tdata;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [pradf_pkg::WIN_W-1:0]     cfg_data_i;

  // Frame identity kept for later replays
  typedef struct packed {
    logic [pradf_pkg::ADDR_W-1:0] ta;
    logic [pradf_pkg::PN_W-1:0]   pn;
    logic                         agg;
  } frame_key_t;

  // Replay table mirror
  logic [pradf_pkg::WIN_W-1:0]  win_model;
  int unsigned                  fill_model;
  pradf_pkg::entry_t            slot_model [SLOTS];

  bit                           flip_expected [$];
  bit                           flip_want;
  frame_key_t                   seen_frames [$];
  logic [pradf_pkg::TIME_W-1:0] obs_time;
  int unsigned                  burst_left;
  int unsigned                  errors = 0;
  int unsigned                  stall_mode;

  pn_replay_amsdu_flip_detector_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Scan the table mirror for one frame, update it, return the flip flag
  function automatic bit flip_of_frame(input logic [pradf_pkg::ADDR_W-1:0] ta,
                                       input logic [pradf_pkg::PN_W-1:0] pn,
                                       input logic agg,
                                       input logic [pradf_pkg::TIME_W-1:0] ts);
    int unsigned i;
    int unsigned reuse;
    bit          have_reuse;
    longint      age;
    reuse      = 0;
    have_reuse = 1'b0;
    for (i = 0; i < fill_model; i++) begin
      // signed age: an entry from the future stays live
      age = longint'(ts) - longint'(slot_model[i].stamp);
      if (age > longint'(win_model)) begin
        if (!have_reuse) begin
          have_reuse = 1'b1;
          reuse      = i;
        end
      end else if (slot_model[i].ta == ta && slot_model[i].pn == pn) begin
        slot_model[i].stamp = ts;
        return slot_model[i].agg != agg;
      end
    end
    if (!have_reuse) begin
      if (fill_model < SLOTS) begin
        reuse = fill_model;
        fill_model++;
      end else begin
        // oldest entry, lowest slot on a tie
        reuse = 0;
        for (i = 1; i < SLOTS; i++)
          if (slot_model[i].stamp < slot_model[reuse].stamp) reuse = i;
      end
    end
    slot_model[reuse] = '{stamp: ts, agg: agg, pn: pn, ta: ta};
    return 1'b0;
  endfunction

  // Send one frame beat; valid stays high after acceptance for back-to-back beats
  task automatic send_frame(input logic [pradf_pkg::ADDR_W-1:0] ta,
                            input logic [pradf_pkg::PN_W-1:0] pn,
                            input logic agg,
                            input logic [pradf_pkg::TIME_W-1:0] ts);
    int unsigned gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {ts, pn, ta};
    s_axis_tuser  = agg;
    do @(posedge clk_i); while (!s_axis_tready);
    flip_expected.push_back(flip_of_frame(ta, pn, agg, ts));
    seen_frames.push_back('{ta: ta, pn: pn, agg: agg});
    if (seen_frames.size() > 96) void'(seen_frames.pop_front());
    burst_left--;
  endtask

  // Stop sending and wait until the block has finished all work
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    burst_left    = 0;
    while (flip_expected.size() != 0) @(posedge clk_i);
    repeat (ITEM_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [pradf_pkg::WIN_W-1:0] value);
    drain_results();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    win_model = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Mix of replays, near-miss addresses and fresh random frames
  task automatic send_random_frame();
    frame_key_t  key;
    int unsigned pick;
    int unsigned step;
    step = $urandom_range(0, 99);
    if (step >= 95)      obs_time -= $urandom_range(1, 4);
    else if (step >= 85) obs_time += $urandom_range(1, 32'(win_model) + 2);
    else if (step >= 60) obs_time += $urandom_range(1, 3);
    pick = $urandom_range(0, 99);
    if (pick < 45 && seen_frames.size() != 0) begin
      key = seen_frames[$urandom_range(0, seen_frames.size() - 1)];
      if ($urandom_range(0, 1) != 0) key.agg = ~key.agg;
    end else if (pick < 80) begin
      key.ta  = 48'h0000_1111_0000 + 48'($urandom_range(0, 5));
      key.pn  = 48'($urandom_range(0, 20));
      key.agg = 1'($urandom_range(0, 1));
    end else begin
      key.ta  = 48'({$urandom, $urandom});
      key.pn  = 48'({$urandom, $urandom});
      key.agg = 1'($urandom_range(0, 1));
    end
    send_frame(key.ta, key.pn, key.agg, obs_time);
  endtask

  // Field extremes, replay with and without flip, aging, decreasing time
  task automatic test_directed();
    send_frame('0, '0, 1'b0, 32'd100);
    send_frame('0, '0, 1'b0, 32'd100);
    send_frame('0, '0, 1'b1, 32'd105);
    // stored bit is never updated by a flip
    send_frame('0, '0, 1'b1, 32'd106);
    send_frame('0, '0, 1'b0, 32'd107);
    send_frame(TA_ONES, PN_ONES, 1'b1, 32'd107);
    send_frame(TA_ONES, '0, 1'b0, 32'd107);
    send_frame('0, PN_ONES, 1'b0, 32'd107);
    // age equal to the window is still live
    send_frame(TA_ONES, PN_ONES, 1'b0, 32'd117);
    // aged entry is not compared and its slot is reused
    send_frame('0, '0, 1'b1, 32'd118);
    // timestamp going backward keeps the entry live
    send_frame('0, '0, 1'b0, 32'd115);
    send_frame(TA_ONES, PN_ONES, 1'b1, 32'd0);
    send_frame('0, 48'd1, 1'b1, '1);
    send_frame('0, 48'd1, 1'b0, '1);
  endtask

  // Zero window: same second live, one second later aged
  task automatic test_window_zero();
    write_window('0);
    obs_time = 32'd5000;
    send_frame(48'h0000_2222_0001, 48'd7, 1'b0, obs_time);
    send_frame(48'h0000_2222_0001, 48'd7, 1'b1, obs_time);
    send_frame(48'h0000_2222_0001, 48'd7, 1'b1, obs_time + 1);
    send_frame(48'h0000_2222_0001, 48'd7, 1'b0, obs_time + 1);
  endtask

  // Overfill the table so the oldest entry gets replaced
  task automatic test_table_full();
    int unsigned n;
    write_window('1);
    obs_time = 32'd200000;
    for (n = 0; n < 70; n++)
      send_frame(48'h0000_3333_0000 + 48'(n), 48'(n), 1'($urandom_range(0, 1)), obs_time);
    for (n = 0; n < 40; n++) begin
      obs_time += $urandom_range(0, 2);
      send_frame(48'h0000_4444_0000 + 48'(n), 48'($urandom), 1'($urandom_range(0, 1)),
                 obs_time);
      // hold off once until the pipeline is empty
      if (n == 20) drain_results();
    end
    for (n = 0; n < 40; n++) send_random_frame();
  endtask

  // Random traffic over several window settings
  task automatic test_window_sweep();
    logic [pradf_pkg::WIN_W-1:0] windows [7];
    int unsigned                 w;
    int unsigned                 n;
    windows = '{16'd1, 16'd10, 16'hFFFF, 16'd3, 16'($urandom), 16'd0, 16'd300};
    for (w = 0; w < 7; w++) begin
      write_window(windows[w]);
      for (n = 0; n < 95; n++) send_random_frame();
    end
  endtask

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (flip_expected.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        flip_want = flip_expected.pop_front();
        if (m_axis_tdata != {{(pradf_pkg::M_TDATA_W-1){1'b0}}, flip_want}) begin
          $display("%0t: flip_detected beat expected %h actual %h", $time,
                   {{(pradf_pkg::M_TDATA_W-1){1'b0}}, flip_want}, m_axis_tdata);
          errors++;
        end
      end
    end
  end

  // Receiver stalls: free-running, random, or mostly blocked
  initial begin
    m_axis_tready = 1'b0;
    stall_mode    = 0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: begin
          m_axis_tready = 1'b1;
        end
        1: begin
          m_axis_tready = ($urandom_range(0, 2) != 0);
        end
        default: begin
          m_axis_tready = ($urandom_range(0, 7) == 0);
        end
      endcase
    end
  end

  initial begin
    #20_000_000;
    $display("pn_replay_amsdu_flip_detector_unit: mismatch");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    burst_left    = 0;
    win_model     = pradf_pkg::WINDOW_RST;
    fill_model    = 0;
    obs_time      = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_window_zero();
    test_table_full();
    test_window_sweep();
    drain_results();

    if (errors == 0) begin
      $display("pn_replay_amsdu_flip_detector_unit: match");
    end else begin
      $display("pn_replay_amsdu_flip_detector_unit: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/pradf_pkg.sv
rtl/core/pn_replay_amsdu_flip_detector_unit.sv
tb/pn_replay_amsdu_flip_detector_unit_tb.sv
